FILE: rtl/dtbb_pkg.sv
package dtbb_pkg;

	localparam int DEF_LINE_MAX = 2048;
	localparam int DEF_COLOR_WEIGHT_ENTRIES = 2048;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

	localparam logic [11:0] FRAME_WIDTH_RESET = 12'd2048;
	localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd2048;

	// Window walk: center first, then the eight neighbors in dilation order.
	localparam int NB_COUNT = 9;
	localparam int DIV_STEPS = 16;

	localparam logic signed [1:0] NB_DX [NB_COUNT] = '{
		2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1
	};
	localparam logic signed [1:0] NB_DY [NB_COUNT] = '{
		2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1
	};
	localparam logic [16:0] SPATIAL_W [NB_COUNT] = '{
		17'd65536, 17'd24109, 17'd39750, 17'd24109, 17'd39750,
		17'd39750, 17'd24109, 17'd39750, 17'd24109
	};

	typedef struct packed {
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic        flush;
	} pix_in_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic        last_pixel;
	} pix_out_t;

	typedef struct packed {
		logic       load;
		logic       raw_wr;
		logic       dil_rd;
		logic       dil_wr;
		logic       blur_rd;
		logic       div_init;
		logic       div_step;
		logic       out_load;
		logic       advance;
		logic [3:0] step;
	} cmd_t;

	typedef struct packed {
		logic ignore;
		logic raw_act;
		logic dil_act;
		logic blur_act;
		logic busy;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/dilate_then_bilateral_blur_3x3_core.sv
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_stall   pix_in_t: red/green/blue 8.8, flush
// out      out  out_valid/out_stall pix_out_t: red/green/blue 8.8, last_pixel
// cfg      in   cfg_valid/cfg_ready cfg_index (0 width, 1 height), cfg_data
//
// One item at a time: an item is either dropped, only stores a pixel, also dilates (nine raw
// line-store reads and one extra step for the last to land), or also yields a result, and a
// drain item may only yield one (nine window reads, a wait for the seven-stage weight
// pipeline to empty, then a 16-step divider).
// A finished beat waits in the output register; while it stalls, the next result waits.
// arst_n clears control state; line stores need no clearing.
module dilate_then_bilateral_blur_3x3_core import dtbb_pkg::*; #(
	parameter int LINE_MAX = DEF_LINE_MAX,
	parameter int COLOR_WEIGHT_ENTRIES = DEF_COLOR_WEIGHT_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pix_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pix_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t st;

	dtbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	dtbb_datapath #(
		.LINE_MAX             (LINE_MAX),
		.COLOR_WEIGHT_ENTRIES (COLOR_WEIGHT_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/dtbb_ctrl.sv
module dtbb_ctrl import dtbb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_RAW, S_DIL, S_DILW, S_BLUR, S_BWAIT, S_DIV, S_OUT, S_ADV
	} state_t;

	state_t     state_q;
	logic [3:0] k_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.step = k_q;
		case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_RAW:   cmd.raw_wr = st.raw_act && !st.ignore;
			S_DIL:   cmd.dil_rd = (k_q < 4'(NB_COUNT));
			S_DILW:  cmd.dil_wr = 1'b1;
			S_BLUR:  cmd.blur_rd = 1'b1;
			S_BWAIT: cmd.div_init = !st.busy;
			S_DIV:   cmd.div_step = 1'b1;
			S_OUT: begin
				cmd.out_load = st.out_free;
				cmd.advance = st.out_free;
			end
			S_ADV:   cmd.advance = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_RAW;
				end
				S_RAW: begin
					k_q <= '0;
					if (st.ignore) state_q <= S_IDLE;
					else if (st.dil_act) state_q <= S_DIL;
					else if (st.blur_act) state_q <= S_BLUR;
					else state_q <= S_ADV;
				end
				S_DIL: begin
					// One extra step lets the last read retire before the write.
					if (k_q == 4'(NB_COUNT)) begin
						k_q <= '0;
						state_q <= S_DILW;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_DILW: begin
					state_q <= st.blur_act ? S_BLUR : S_ADV;
				end
				S_BLUR: begin
					if (k_q == 4'(NB_COUNT - 1)) begin
						k_q <= '0;
						state_q <= S_BWAIT;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_BWAIT: begin
					if (!st.busy) begin
						k_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (k_q == 4'(DIV_STEPS - 1)) begin
						k_q <= '0;
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_OUT: begin
					if (st.out_free) state_q <= S_IDLE;
				end
				S_ADV:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free) else $error("result loaded over a pending beat");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.raw_wr, cmd.dil_rd, cmd.dil_wr, cmd.blur_rd, cmd.div_init,
			cmd.div_step})) else $error("datapath commands overlap");
	a_div_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !st.busy) else $error("divide started before weights settled");
`endif

endmodule

FILE: rtl/dtbb_datapath.sv
module dtbb_datapath import dtbb_pkg::*; #(
	parameter int LINE_MAX = DEF_LINE_MAX,
	parameter int COLOR_WEIGHT_ENTRIES = DEF_COLOR_WEIGHT_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 st,
	input  pix_in_t               in_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pix_out_t              out_data
);

	localparam int XW = $clog2(LINE_MAX);
	localparam int WW = $clog2(LINE_MAX + 1);
	localparam int AW = XW + 2;
	localparam int DEPTH = 4 << XW;
	localparam longint PosMax = longint'(LINE_MAX) * 65535 + 2 * longint'(LINE_MAX) + 3;
	localparam int POS_W = $clog2(PosMax);
	localparam int CNW = $clog2(COLOR_WEIGHT_ENTRIES + 1);
	localparam int CIW = $clog2(COLOR_WEIGHT_ENTRIES);
	localparam int PW = 34 + CNW;
	localparam longint unsigned CW_X = (64'd20 << 30) / COLOR_WEIGHT_ENTRIES;

	typedef logic [16:0] rom_t [COLOR_WEIGHT_ENTRIES];

	// Shift-and-subtract division, used only while the table is built.
	function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-d2/0.2) in Q16 as a geometric series of one-step factors.
	function automatic rom_t build_rom();
		longint unsigned sum;
		longint unsigned term;
		longint unsigned w;
		rom_t r;
		sum = 64'd1 << 30;
		term = 64'd1 << 30;
		w = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = div_u64((term * CW_X) >> 30, 64'(k));
			if ((k & 1) == 1) sum = sum - term;
			else sum = sum + term;
		end
		for (int i = 0; i < COLOR_WEIGHT_ENTRIES; i++) begin
			r[i] = 17'((w + (64'd1 << 13)) >> 14);
			w = (w * sum + (64'd1 << 29)) >> 30;
		end
		return r;
	endfunction

	localparam rom_t CW_ROM = build_rom();

	// Configuration and frame geometry.
	logic [11:0]      fw_q;
	logic [15:0]      fh_q;
	logic             cfg_hit;
	logic [31:0]      fw32;
	logic [31:0]      ew32;
	logic [WW-1:0]    eff_w;
	logic [15:0]      eff_h;
	logic [POS_W-1:0] total_q;
	logic [POS_W-1:0] wp;
	logic [POS_W-1:0] d_lo;
	logic [POS_W-1:0] b_lo;
	logic             last;

	// Frame position.
	logic [POS_W-1:0] p_q;
	logic [XW-1:0]    xr_q, xd_q, xb_q;
	logic [15:0]      yr_q, yd_q, yb_q;
	logic             flush_q;
	logic [47:0]      pix_q;

	// Neighbor addressing.
	logic [3:0]              nk;
	logic [XW-1:0]           bx;
	logic [15:0]             by;
	logic signed [1:0]       dx, dy;
	logic                    x_ok, y_ok, nb_in;
	logic [XW-1:0]           nx;
	logic [1:0]              ny;
	logic [AW-1:0]           nb_addr;

	logic [47:0] raw_mem [DEPTH];
	logic [47:0] dil_mem [DEPTH];
	logic [47:0] raw_rd_s1;
	logic [47:0] dil_rd_s1;

	// Dilation.
	logic        dv_s1, din_s1;
	logic [47:0] c_q;

	// Blur pipeline.
	logic        bv_s1, bv_s2, bv_s3, bv_s4, bv_s5, bv_s6, bv_s7;
	logic        bin_s1, bin_s2, bin_s3, bin_s4, bin_s5;
	logic [3:0]  bk_s1;
	logic [47:0] ctr_q;
	logic [47:0] ctr;
	logic [15:0] dif [3];
	logic [31:0] sq_s2 [3];
	logic [47:0] nb_s2, nb_s3, nb_s4, nb_s5, nb_s6;
	logic [16:0] ws_s2, ws_s3, ws_s4, ws_s5;
	logic [33:0] d2_s3;
	logic [PW-1:0] idx_prod;
	logic [PW-1:0] idx_full;
	logic [CIW-1:0] idx_s4;
	logic        ok_s4;
	logic [16:0] wc_s5;
	logic [33:0] wt_prod;
	logic [16:0] wt_s6, wt_s7;
	logic [32:0] mul_s7 [3];
	logic [35:0] acc_q [3];
	logic [19:0] wsum_q;

	// Divider.
	logic [35:0] rem_q [3];
	logic [34:0] den_q;
	logic [15:0] quo_q [3];

	logic     out_valid_q;
	pix_out_t out_q;

	assign cfg_ready = 1'b1;
	assign cfg_hit = cfg_valid &&
		(cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RESET;
			fh_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FRAME_WIDTH) fw_q <= cfg_data[11:0];
			if (cfg_index == REG_FRAME_HEIGHT) fh_q <= cfg_data;
		end
	end

	always_comb begin
		fw32 = 32'(fw_q);
		if (fw_q == 12'd0) ew32 = 32'd1;
		else if (fw32 > 32'(LINE_MAX)) ew32 = 32'(LINE_MAX);
		else ew32 = fw32;
		eff_w = ew32[WW-1:0];
		eff_h = (fh_q == 16'd0) ? 16'd1 : fh_q;
	end

	always_ff @(posedge clk) begin
		total_q <= POS_W'(eff_w) * POS_W'(eff_h);
	end

	always_comb begin
		wp = POS_W'(eff_w);
		d_lo = wp + POS_W'(1);
		b_lo = (wp << 1) + POS_W'(2);
		st.raw_act = p_q < total_q;
		st.dil_act = (p_q >= d_lo) && (p_q < total_q + d_lo);
		st.blur_act = (p_q >= b_lo) && (p_q < total_q + b_lo);
		st.ignore = flush_q && st.raw_act;
		st.busy = bv_s1 | bv_s2 | bv_s3 | bv_s4 | bv_s5 | bv_s6 | bv_s7;
		st.out_free = !out_valid_q || !out_stall;
		last = (p_q == total_q + b_lo - POS_W'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flush_q <= in_data.flush;
			pix_q <= {in_data.blue_in, in_data.green_in, in_data.red_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			xr_q <= '0; yr_q <= '0;
			xd_q <= '0; yd_q <= '0;
			xb_q <= '0; yb_q <= '0;
		end else if (cfg_hit || (cmd.advance && last)) begin
			p_q <= '0;
			xr_q <= '0; yr_q <= '0;
			xd_q <= '0; yd_q <= '0;
			xb_q <= '0; yb_q <= '0;
		end else if (cmd.advance) begin
			p_q <= p_q + POS_W'(1);
			if (st.raw_act) begin
				if (WW'(xr_q) == eff_w - WW'(1)) begin
					xr_q <= '0;
					yr_q <= yr_q + 16'd1;
				end else begin
					xr_q <= xr_q + XW'(1);
				end
			end
			if (st.dil_act) begin
				if (WW'(xd_q) == eff_w - WW'(1)) begin
					xd_q <= '0;
					yd_q <= yd_q + 16'd1;
				end else begin
					xd_q <= xd_q + XW'(1);
				end
			end
			if (st.blur_act) begin
				if (WW'(xb_q) == eff_w - WW'(1)) begin
					xb_q <= '0;
					yb_q <= yb_q + 16'd1;
				end else begin
					xb_q <= xb_q + XW'(1);
				end
			end
		end
	end

	always_comb begin
		nk = (cmd.step > 4'(NB_COUNT - 1)) ? 4'd0 : cmd.step;
		bx = cmd.blur_rd ? xb_q : xd_q;
		by = cmd.blur_rd ? yb_q : yd_q;
		dx = NB_DX[nk];
		dy = NB_DY[nk];
		if (dx[1]) x_ok = (bx != '0);
		else if (dx == 2'sd1) x_ok = (WW'(bx) + WW'(1)) < eff_w;
		else x_ok = 1'b1;
		if (dy[1]) y_ok = (by != 16'd0);
		else if (dy == 2'sd1) y_ok = (17'(by) + 17'd1) < 17'(eff_h);
		else y_ok = 1'b1;
		nx = bx + {{(XW-2){dx[1]}}, dx};
		ny = by[1:0] + dy;
		nb_addr = {ny, nx};
		nb_in = x_ok && y_ok;
	end

	always_ff @(posedge clk) begin
		if (cmd.raw_wr) raw_mem[{yr_q[1:0], xr_q}] <= pix_q;
		if (cmd.dil_rd) raw_rd_s1 <= raw_mem[nb_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.dil_wr) dil_mem[{yd_q[1:0], xd_q}] <= c_q;
		if (cmd.blur_rd) dil_rd_s1 <= dil_mem[nb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
			bv_s1 <= 1'b0; bv_s2 <= 1'b0; bv_s3 <= 1'b0; bv_s4 <= 1'b0;
			bv_s5 <= 1'b0; bv_s6 <= 1'b0; bv_s7 <= 1'b0;
		end else begin
			dv_s1 <= cmd.dil_rd;
			bv_s1 <= cmd.blur_rd;
			bv_s2 <= bv_s1; bv_s3 <= bv_s2; bv_s4 <= bv_s3;
			bv_s5 <= bv_s4; bv_s6 <= bv_s5; bv_s7 <= bv_s6;
		end
	end

	// A black pixel keeps the first non-black in-frame neighbor it meets.
	always_ff @(posedge clk) begin
		din_s1 <= nb_in;
		if (cmd.load) c_q <= '0;
		else if (dv_s1 && c_q == 48'd0 && din_s1) c_q <= raw_rd_s1;
	end

	always_comb begin
		ctr = (bk_s1 == 4'd0) ? dil_rd_s1 : ctr_q;
		for (int c = 0; c < 3; c++) begin
			if (dil_rd_s1[16*c +: 16] > ctr[16*c +: 16])
				dif[c] = dil_rd_s1[16*c +: 16] - ctr[16*c +: 16];
			else
				dif[c] = ctr[16*c +: 16] - dil_rd_s1[16*c +: 16];
		end
		idx_prod = PW'(d2_s3) * PW'(COLOR_WEIGHT_ENTRIES);
		idx_full = idx_prod >> 18;
		wt_prod = 34'(ws_s5) * 34'(wc_s5);
	end

	always_ff @(posedge clk) begin
		bin_s1 <= nb_in;
		bk_s1 <= nk;
		if (bv_s1 && bk_s1 == 4'd0) ctr_q <= dil_rd_s1;

		for (int c = 0; c < 3; c++) sq_s2[c] <= 32'(dif[c]) * 32'(dif[c]);
		nb_s2 <= dil_rd_s1;
		ws_s2 <= SPATIAL_W[bk_s1];
		bin_s2 <= bin_s1;

		d2_s3 <= 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);
		nb_s3 <= nb_s2;
		ws_s3 <= ws_s2;
		bin_s3 <= bin_s2;

		idx_s4 <= idx_full[CIW-1:0];
		ok_s4 <= idx_full < PW'(COLOR_WEIGHT_ENTRIES);
		nb_s4 <= nb_s3;
		ws_s4 <= ws_s3;
		bin_s4 <= bin_s3;

		wc_s5 <= ok_s4 ? CW_ROM[idx_s4] : 17'd0;
		nb_s5 <= nb_s4;
		ws_s5 <= ws_s4;
		bin_s5 <= bin_s4;

		wt_s6 <= bin_s5 ? wt_prod[32:16] : 17'd0;
		nb_s6 <= nb_s5;

		for (int c = 0; c < 3; c++) mul_s7[c] <= 33'(nb_s6[16*c +: 16]) * 33'(wt_s6);
		wt_s7 <= wt_s6;

		if (cmd.load) begin
			for (int c = 0; c < 3; c++) acc_q[c] <= '0;
			wsum_q <= '0;
		end else if (bv_s7) begin
			for (int c = 0; c < 3; c++) acc_q[c] <= acc_q[c] + 36'(mul_s7[c]);
			wsum_q <= wsum_q + 20'(wt_s7);
		end
	end

	// Restoring divide, one quotient bit per step for all three channels.
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= acc_q[c];
				quo_q[c] <= '0;
			end
			den_q <= {wsum_q, 15'd0};
		end else if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				if (rem_q[c] >= {1'b0, den_q}) begin
					rem_q[c] <= rem_q[c] - {1'b0, den_q};
					quo_q[c] <= {quo_q[c][14:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][14:0], 1'b0};
				end
			end
			den_q <= den_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.red_out <= quo_q[0];
			out_q.green_out <= quo_q[1];
			out_q.blue_out <= quo_q[2];
			out_q.last_pixel <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef ASSERT_OFF
	a_wsum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> (wsum_q != 20'd0)) else $error("weight total is zero at divide");
	a_dil_retired: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dil_wr |-> !dv_s1) else $error("dilated pixel written before last read");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load)) else $error("output beat without a result");
`endif

endmodule
